>>> hdl/sacfc_pkg.sv
// ----------------------------------------------------------------------------
// sacfc_pkg
// shared constants and types of the set-associative fifo-replacement cache
// ----------------------------------------------------------------------------
package sacfc_pkg;

  localparam int unsigned SETS      = 4;
  localparam int unsigned WAYS      = 4;
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned TAG_W  = ADDR_BITS - SET_W;
  localparam int unsigned ROW_W  = WAYS * TAG_W;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned OADDR_W = 32;

  typedef logic [SET_W-1:0] set_t;
  typedef logic [WAY_W-1:0] way_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [ROW_W-1:0] row_t;

  // outcome of one tag lookup
  typedef struct packed {
    logic hit;
    way_t way;
    logic evict;
    tag_t victim_tag;
  } match_t;

endpackage

>>> hdl/sacfc_tag_ram.sv
// ----------------------------------------------------------------------------
// sacfc_tag_ram
// tag memory, one row of all ways per set, registered read port
// ----------------------------------------------------------------------------
module sacfc_tag_ram
  import sacfc_pkg::*;
(
  input  logic clk_i,
  input  logic re_i,
  input  set_t raddr_i,
  output row_t rdata_o,
  input  logic we_i,
  input  set_t waddr_i,
  input  row_t wdata_i
);

  row_t mem [SETS];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sacfc_match.sv
// ----------------------------------------------------------------------------
// sacfc_match
// parallel way compare and fifo victim selection for one set
// ----------------------------------------------------------------------------
module sacfc_match
  import sacfc_pkg::*;
(
  input  row_t             row_i,
  input  logic [WAYS-1:0]  valid_i,
  input  tag_t             tag_i,
  input  way_t             fifo_ptr_i,
  output match_t           match_o
);

  logic [WAYS-1:0] eq;
  logic            found;
  way_t            found_way;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      eq[w] = valid_i[w] && (row_i[w*TAG_W +: TAG_W] == tag_i);
    end
  end

  // lowest matching way wins
  always_comb begin
    found     = 1'b0;
    found_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (eq[w]) begin
        found     = 1'b1;
        found_way = way_t'(w);
      end
    end
  end

  always_comb begin
    match_o.hit        = found;
    match_o.way        = found ? found_way : fifo_ptr_i;
    match_o.evict      = !found && valid_i[fifo_ptr_i];
    match_o.victim_tag = row_i[fifo_ptr_i*TAG_W +: TAG_W];
  end

endmodule

>>> hdl/set_assoc_fifo_cache_model_top.sv
// ----------------------------------------------------------------------------
// set_assoc_fifo_cache_model_top
// tag store of a 4-set, 4-way cache with per-set fifo replacement
// ----------------------------------------------------------------------------
// usage
// - raise start_i with a block address on block_address_i; the item is taken
//   at a clock edge where start_i is high and busy_o is low
// - the low address bits pick the set, the rest is the tag
// - lookup state after accept: the set's tag row comes out of the tag memory and
//   is compared against all ways in parallel; on a miss the row is written
//   back with the new tag at the set's fifo pointer
// - on leaving the lookup state: result_valid_o pulses for exactly one cycle with
//   hit, set, way, eviction info and the saturating hit / miss totals
// - busy_o covers the lookup state, so a new item is taken only after the
//   read-compare-write of the last one, but while its result is shown
// - the item that follows reads the memory after the write back, so two
//   items to the same set never see stale tags
// - the receiver cannot stall: each result is there for one cycle only
// - reset clears the valid bits, fifo pointers and both counters; the tag
//   memory itself is not cleared, invalid ways are never looked at
// ----------------------------------------------------------------------------
module set_assoc_fifo_cache_model_top
  import sacfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [31:0]         block_address_i,
  output logic                result_valid_o,
  output logic                hit_o,
  output logic [IDX_W-1:0]    set_index_o,
  output logic [IDX_W-1:0]    way_index_o,
  output logic                evicted_o,
  output logic [OADDR_W-1:0]  evicted_address_o,
  output logic [CNT_W-1:0]    hit_total_o,
  output logic [CNT_W-1:0]    miss_total_o
);

  // controller codes
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic state_q, state_d;

  logic accept;
  logic [ADDR_BITS-1:0] addr_q;
  set_t set_cur;
  tag_t tag_cur;

  // per-set control state kept in flops
  logic [SETS-1:0][WAYS-1:0] valid_q;
  way_t [SETS-1:0]           fifo_q;

  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;

  // result registers
  logic                strobe_q;
  logic                hit_q;
  set_t                set_q;
  way_t                way_q;
  logic                ev_q;
  logic [OADDR_W-1:0]  ev_addr_q;

  row_t   row_rd;
  row_t   row_wr;
  logic   mem_we;
  match_t mt;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign set_cur = addr_q[SET_W-1:0];
  assign tag_cur = addr_q[ADDR_BITS-1:SET_W];

  // tag memory: read on accept, write back on a miss
  sacfc_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (block_address_i[SET_W-1:0]),
    .rdata_o (row_rd),
    .we_i    (mem_we),
    .waddr_i (set_cur),
    .wdata_i (row_wr)
  );

  sacfc_match u_match (
    .row_i      (row_rd),
    .valid_i    (valid_q[set_cur]),
    .tag_i      (tag_cur),
    .fifo_ptr_i (fifo_q[set_cur]),
    .match_o    (mt)
  );

  assign mem_we = (state_q == ST_LOOKUP) && !mt.hit;

  // fill the victim way with the new tag
  always_comb begin
    row_wr = row_rd;
    row_wr[mt.way*TAG_W +: TAG_W] = tag_cur;
  end

  // saturating counters
  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (state_q == ST_LOOKUP) begin
      if (mt.hit) begin
        if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 1'b1;
      end else begin
        if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      fifo_q     <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      strobe_q   <= (state_q == ST_LOOKUP);
      if (mem_we) begin
        valid_q[set_cur][mt.way] <= 1'b1;
        // advance the set's pointer, wrapping at the way count
        fifo_q[set_cur] <= (mt.way == way_t'(WAYS - 1)) ? '0 : mt.way + 1'b1;
      end
    end
  end

  // address and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= block_address_i[ADDR_BITS-1:0];
    end
    if (state_q == ST_LOOKUP) begin
      hit_q     <= mt.hit;
      set_q     <= set_cur;
      way_q     <= mt.way;
      ev_q      <= mt.evict;
      // evicted block address is the victim tag with the set appended
      ev_addr_q <= mt.evict ? OADDR_W'({mt.victim_tag, set_cur}) : '0;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = strobe_q;
  assign hit_o             = hit_q;
  assign set_index_o       = IDX_W'(set_q);
  assign way_index_o       = IDX_W'(way_q);
  assign evicted_o         = ev_q;
  assign evicted_address_o = ev_addr_q;
  assign hit_total_o       = hit_cnt_q;
  assign miss_total_o      = miss_cnt_q;

  // a result only ever leaves while the controller is back in idle
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  // every accepted item reaches lookup on the next cycle and a result after
  a_accept_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 strobe_q)
    else $error("accepted item gave no result");

  // a miss leaves the hit total untouched
  a_miss_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !hit_q) |-> (hit_cnt_q == $past(hit_cnt_q)))
    else $error("hit total moved on a miss");

  // eviction only on a miss
  a_evict_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && ev_q) |-> !hit_q)
    else $error("eviction reported on a hit");

endmodule
